// ===== hw/rtl/csfm_pkg.sv =====
`timescale 1ns / 1ps

package csfm_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_WATER_TEMP_CONTROL   = 3'd0;
    localparam logic [2:0] CFG_LOW_ALARM_THRESHOLD  = 3'd1;
    localparam logic [2:0] CFG_HIGH_ALARM_THRESHOLD = 3'd2;
    localparam logic [2:0] CFG_LINK_ENABLE_MASK     = 3'd3;
    localparam logic [2:0] CFG_TIME_LIMIT_ENABLE    = 3'd4;
    localparam logic [2:0] CFG_TIME_LIMIT_HOURS     = 3'd5;

    // Operating modes
    localparam logic [2:0] MODE_COOL = 3'd1;
    localparam logic [2:0] MODE_HEAT = 3'd2;

    // Temperature limits, tenths of a degree
    localparam logic signed [15:0] SENSOR_LOW_LIMIT  = -16'sd400;
    localparam logic signed [15:0] SENSOR_HIGH_LIMIT = 16'sd800;
    localparam logic signed [15:0] HYSTERESIS        = 16'sd60;

    // Timer loads, seconds
    localparam logic [7:0] FLOW_WINDOW_SECONDS  = 8'd180;
    localparam logic [4:0] PUMP_START_SECONDS   = 5'd20;
    localparam logic [5:0] FLOW_CLEAR_SECONDS   = 6'd60;
    localparam logic [2:0] HOLD_SECONDS         = 3'd5;
    localparam logic [1:0] TEMP_QUALIFY_SECONDS = 2'd2;

    // Latched fault bits
    localparam int F_SENSOR = 0;
    localparam int F_COOL   = 1;
    localparam int F_HEAT   = 2;
    localparam int F_FLOW   = 3;
    localparam int F_OVER   = 4;
    localparam int F_TIME   = 5;

    typedef struct packed {
        logic               water_temp_control;
        logic signed [10:0] low_alarm_threshold;
        logic signed [10:0] high_alarm_threshold;
        logic [3:0]         link_enable_mask;
        logic               time_limit_enable;
        logic [15:0]        time_limit_hours;
    } cfg_t;

    typedef struct packed {
        logic               second_tick;
        logic signed [15:0] sensor_outlet_temp;
        logic signed [15:0] system_outlet_temp;
        logic [2:0]         set_mode;
        logic [4:0]         active_units;
        logic               flow_switch_on;
        logic               pump_on;
        logic               overload_feedback_ok;
        logic [3:0]         link_lost_flags;
        logic [31:0]        run_minutes;
        logic [3:0]         network_error_flags;
    } item_t;

    // Packed so that alarm_flags sits in the low bits
    typedef struct packed {
        logic        any_alarm;
        logic [14:0] alarm_flags;
    } result_t;

endpackage

// ===== hw/rtl/chiller_system_fault_monitor.sv =====
`timescale 1ns / 1ps

// Chiller system fault monitor.
// s_* carries one evaluation item per controller pass; m_* returns one alarm
// result per item, in order. cfg_* writes one configuration register per
// transfer (cfg_index selects it, unknown indexes are ignored); cfg_ready is
// always high, and writes are expected only while no item is in flight.
// An item is held in the input register, then evaluated by the fault logic
// into the result register, which drives m_tvalid. While the receiver
// accepts results, the block sustains one item per cycle: the input
// register refills in the same cycle its item moves to the result register.
// When the receiver stalls, the result register holds and the input
// register keeps one more item, then s_tready drops.
// Reset clears all timers, latched faults, the sensor lock and the flow
// confirmation, empties both registers, and loads the configuration
// defaults (thresholds 4.0 and 60.0 degrees, everything else off).
module chiller_system_fault_monitor
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input item stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // low to high: second_tick[0], sensor_outlet_temp[16:1],
    // system_outlet_temp[32:17], set_mode[35:33], active_units[40:36],
    // flow_switch_on[41], pump_on[42], overload_feedback_ok[43],
    // link_lost_flags[47:44], run_minutes[79:48], network_error_flags[83:80]
    input  logic [87:0] s_tdata,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // low to high: alarm_flags[14:0], any_alarm[15]
    output logic [15:0] m_tdata
);

    csfm_pkg::cfg_t    cfg;
    csfm_pkg::item_t   item_reg;
    csfm_pkg::result_t core_result;
    csfm_pkg::result_t result_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              advance;

    assign cfg_ready = 1'b1;

    csfm_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Item moves to the result register when that register is empty or its result is taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.second_tick          <= s_tdata[0];
            item_reg.sensor_outlet_temp   <= s_tdata[16:1];
            item_reg.system_outlet_temp   <= s_tdata[32:17];
            item_reg.set_mode             <= s_tdata[35:33];
            item_reg.active_units         <= s_tdata[40:36];
            item_reg.flow_switch_on       <= s_tdata[41];
            item_reg.pump_on              <= s_tdata[42];
            item_reg.overload_feedback_ok <= s_tdata[43];
            item_reg.link_lost_flags      <= s_tdata[47:44];
            item_reg.run_minutes          <= s_tdata[79:48];
            item_reg.network_error_flags  <= s_tdata[83:80];
        end
    end

    csfm_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= core_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

endmodule

// ===== hw/rtl/csfm_cfg_regs.sv =====
`timescale 1ns / 1ps

module csfm_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [2:0]          wr_index,
    input  logic [15:0]         wr_data,
    output csfm_pkg::cfg_t      cfg
);

    csfm_pkg::cfg_t cfg_reg;
    csfm_pkg::cfg_t cfg_next;

    // Register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                csfm_pkg::CFG_WATER_TEMP_CONTROL:
                    cfg_next.water_temp_control = wr_data[0];
                csfm_pkg::CFG_LOW_ALARM_THRESHOLD:
                    cfg_next.low_alarm_threshold = wr_data[10:0];
                csfm_pkg::CFG_HIGH_ALARM_THRESHOLD:
                    cfg_next.high_alarm_threshold = wr_data[10:0];
                csfm_pkg::CFG_LINK_ENABLE_MASK:
                    cfg_next.link_enable_mask = wr_data[3:0];
                csfm_pkg::CFG_TIME_LIMIT_ENABLE:
                    cfg_next.time_limit_enable = wr_data[0];
                csfm_pkg::CFG_TIME_LIMIT_HOURS:
                    cfg_next.time_limit_hours = wr_data;
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.water_temp_control   <= 1'b0;
            cfg_reg.low_alarm_threshold  <= 11'sd40;
            cfg_reg.high_alarm_threshold <= 11'sd600;
            cfg_reg.link_enable_mask     <= 4'd0;
            cfg_reg.time_limit_enable    <= 1'b0;
            cfg_reg.time_limit_hours     <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/csfm_core.sv =====
`timescale 1ns / 1ps

module csfm_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  csfm_pkg::item_t     item,
    input  csfm_pkg::cfg_t      cfg,
    output csfm_pkg::result_t   result
);

    logic [2:0] sensor_timer_reg,      sensor_timer_next;
    logic [1:0] cool_low_timer_reg,    cool_low_timer_next;
    logic [1:0] heat_high_timer_reg,   heat_high_timer_next;
    logic [4:0] pump_start_timer_reg,  pump_start_timer_next;
    logic [7:0] flow_window_timer_reg, flow_window_timer_next;
    logic [5:0] flow_clear_timer_reg,  flow_clear_timer_next;
    logic [2:0] flow_closed_timer_reg, flow_closed_timer_next;
    logic [2:0] flow_open_timer_reg,   flow_open_timer_next;
    logic [2:0] overload_timer_reg,    overload_timer_next;
    logic [5:0] latched_reg,           latched_next;
    logic       sensor_lock_reg,       sensor_lock_next;
    logic       flow_confirmed_reg,    flow_confirmed_next;

    logic signed [15:0] raw_temp;
    logic signed [15:0] sys_temp;
    logic signed [15:0] low_level;
    logic signed [15:0] high_level;
    logic signed [15:0] cool_clear_level;
    logic signed [15:0] heat_clear_level;
    logic [21:0]        limit_minutes;
    logic               heat_cool;
    logic               sensor_check_on;
    logic               sensor_bad;
    logic               tick;

    // Operand preparation
    assign raw_temp         = item.sensor_outlet_temp;
    assign sys_temp         = item.system_outlet_temp;
    assign low_level        = {{5{cfg.low_alarm_threshold[10]}}, cfg.low_alarm_threshold};
    assign high_level       = {{5{cfg.high_alarm_threshold[10]}}, cfg.high_alarm_threshold};
    assign cool_clear_level = low_level + csfm_pkg::HYSTERESIS;
    assign heat_clear_level = high_level - csfm_pkg::HYSTERESIS;
    // hours * 60 as hours * 64 - hours * 4
    assign limit_minutes    = {cfg.time_limit_hours, 6'b0} - {4'b0, cfg.time_limit_hours, 2'b0};
    assign heat_cool        = (item.set_mode == csfm_pkg::MODE_COOL)
                           || (item.set_mode == csfm_pkg::MODE_HEAT);
    assign sensor_check_on  = cfg.water_temp_control && (item.active_units > 5'd1);
    assign sensor_bad       = (raw_temp <= csfm_pkg::SENSOR_LOW_LIMIT)
                           || (raw_temp >= csfm_pkg::SENSOR_HIGH_LIMIT);
    assign tick             = item.second_tick;

    // Fault qualification, evaluated in order on the running next values
    always_comb
    begin
        // seconds countdown
        sensor_timer_next      = (tick && sensor_timer_reg != '0)
                               ? sensor_timer_reg - 3'd1 : sensor_timer_reg;
        cool_low_timer_next    = (tick && cool_low_timer_reg != '0)
                               ? cool_low_timer_reg - 2'd1 : cool_low_timer_reg;
        heat_high_timer_next   = (tick && heat_high_timer_reg != '0)
                               ? heat_high_timer_reg - 2'd1 : heat_high_timer_reg;
        pump_start_timer_next  = (tick && pump_start_timer_reg != '0)
                               ? pump_start_timer_reg - 5'd1 : pump_start_timer_reg;
        flow_window_timer_next = (tick && flow_window_timer_reg != '0)
                               ? flow_window_timer_reg - 8'd1 : flow_window_timer_reg;
        flow_clear_timer_next  = (tick && flow_clear_timer_reg != '0)
                               ? flow_clear_timer_reg - 6'd1 : flow_clear_timer_reg;
        flow_closed_timer_next = (tick && flow_closed_timer_reg != '0)
                               ? flow_closed_timer_reg - 3'd1 : flow_closed_timer_reg;
        flow_open_timer_next   = (tick && flow_open_timer_reg != '0)
                               ? flow_open_timer_reg - 3'd1 : flow_open_timer_reg;
        overload_timer_next    = (tick && overload_timer_reg != '0)
                               ? overload_timer_reg - 3'd1 : overload_timer_reg;
        latched_next           = latched_reg;
        sensor_lock_next       = sensor_lock_reg;
        flow_confirmed_next    = flow_confirmed_reg;

        // outlet sensor range
        if (sensor_check_on)
        begin
            if (!latched_next[csfm_pkg::F_SENSOR])
            begin
                if (sensor_bad)
                begin
                    if (sensor_timer_next == '0)
                    begin
                        if (heat_cool)
                        begin
                            sensor_lock_next  = 1'b1;
                            sensor_timer_next = csfm_pkg::HOLD_SECONDS;
                        end
                        latched_next[csfm_pkg::F_SENSOR] = 1'b1;
                    end
                end
                else
                begin
                    sensor_timer_next = csfm_pkg::HOLD_SECONDS;
                end
            end
            else if (sensor_bad)
            begin
                sensor_timer_next = csfm_pkg::HOLD_SECONDS;
            end
            else if (sensor_timer_next == '0 && !sensor_lock_next)
            begin
                latched_next[csfm_pkg::F_SENSOR] = 1'b0;
                sensor_timer_next = csfm_pkg::HOLD_SECONDS;
            end
        end
        else
        begin
            latched_next[csfm_pkg::F_SENSOR] = 1'b0;
        end

        // cooling outlet too low
        if (!latched_next[csfm_pkg::F_COOL])
        begin
            if (sys_temp <= low_level && item.set_mode == csfm_pkg::MODE_COOL)
            begin
                if (cool_low_timer_next == '0)
                    latched_next[csfm_pkg::F_COOL] = 1'b1;
            end
            else
            begin
                cool_low_timer_next = csfm_pkg::TEMP_QUALIFY_SECONDS;
            end
        end
        else if (sys_temp >= cool_clear_level)
        begin
            latched_next[csfm_pkg::F_COOL] = 1'b0;
        end

        // heating outlet too high
        if (!latched_next[csfm_pkg::F_HEAT])
        begin
            if (sys_temp >= high_level && item.set_mode == csfm_pkg::MODE_HEAT)
            begin
                if (heat_high_timer_next == '0)
                    latched_next[csfm_pkg::F_HEAT] = 1'b1;
            end
            else
            begin
                heat_high_timer_next = csfm_pkg::TEMP_QUALIFY_SECONDS;
            end
        end
        else if (sys_temp <= heat_clear_level)
        begin
            latched_next[csfm_pkg::F_HEAT] = 1'b0;
        end

        // water flow: start wait, confirm window, then loss watch
        if (!item.pump_on)
        begin
            pump_start_timer_next  = csfm_pkg::PUMP_START_SECONDS;
            flow_window_timer_next = csfm_pkg::FLOW_WINDOW_SECONDS;
            flow_open_timer_next   = csfm_pkg::HOLD_SECONDS;
            flow_closed_timer_next = csfm_pkg::HOLD_SECONDS;
            flow_confirmed_next    = 1'b0;
        end
        if (!latched_next[csfm_pkg::F_FLOW])
        begin
            if (pump_start_timer_next == '0)
            begin
                if (!flow_confirmed_next)
                begin
                    if (!item.flow_switch_on)
                        flow_open_timer_next = csfm_pkg::HOLD_SECONDS;
                    if (flow_open_timer_next == '0)
                        flow_confirmed_next = 1'b1;
                end
                if (!flow_confirmed_next)
                begin
                    if (flow_window_timer_next == '0)
                        latched_next[csfm_pkg::F_FLOW] = 1'b1;
                end
                else
                begin
                    if (item.flow_switch_on)
                        flow_closed_timer_next = csfm_pkg::HOLD_SECONDS;
                    if (flow_closed_timer_next == '0)
                        latched_next[csfm_pkg::F_FLOW] = 1'b1;
                end
                if (latched_next[csfm_pkg::F_FLOW] && heat_cool)
                    flow_clear_timer_next = csfm_pkg::FLOW_CLEAR_SECONDS;
            end
        end
        else if (flow_clear_timer_next == '0)
        begin
            latched_next[csfm_pkg::F_FLOW] = 1'b0;
        end

        // pump overload
        if (pump_start_timer_next == '0)
        begin
            if (!latched_next[csfm_pkg::F_OVER])
            begin
                if (!item.overload_feedback_ok)
                begin
                    if (overload_timer_next == '0)
                    begin
                        overload_timer_next = csfm_pkg::HOLD_SECONDS;
                        latched_next[csfm_pkg::F_OVER] = 1'b1;
                    end
                end
                else
                begin
                    overload_timer_next = csfm_pkg::HOLD_SECONDS;
                end
            end
            else if (!item.overload_feedback_ok)
            begin
                overload_timer_next = csfm_pkg::HOLD_SECONDS;
            end
            else if (overload_timer_next == '0)
            begin
                latched_next[csfm_pkg::F_OVER] = 1'b0;
            end
        end

        // run-time limit
        if (cfg.time_limit_enable)
        begin
            if (item.run_minutes >= {10'b0, limit_minutes})
                latched_next[csfm_pkg::F_TIME] = 1'b1;
        end
        else
        begin
            latched_next[csfm_pkg::F_TIME] = 1'b0;
        end
    end

    // Result: a disabled link reads as a fault
    assign result.alarm_flags = {1'b0,
                                 item.network_error_flags,
                                 latched_next[csfm_pkg::F_TIME],
                                 ~cfg.link_enable_mask | item.link_lost_flags,
                                 latched_next[4:0]};
    assign result.any_alarm   = |result.alarm_flags;

    // State update once per evaluated item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_timer_reg      <= '0;
            cool_low_timer_reg    <= '0;
            heat_high_timer_reg   <= '0;
            pump_start_timer_reg  <= '0;
            flow_window_timer_reg <= '0;
            flow_clear_timer_reg  <= '0;
            flow_closed_timer_reg <= '0;
            flow_open_timer_reg   <= '0;
            overload_timer_reg    <= '0;
            latched_reg           <= '0;
            sensor_lock_reg       <= 1'b0;
            flow_confirmed_reg    <= 1'b0;
        end
        else if (advance)
        begin
            sensor_timer_reg      <= sensor_timer_next;
            cool_low_timer_reg    <= cool_low_timer_next;
            heat_high_timer_reg   <= heat_high_timer_next;
            pump_start_timer_reg  <= pump_start_timer_next;
            flow_window_timer_reg <= flow_window_timer_next;
            flow_clear_timer_reg  <= flow_clear_timer_next;
            flow_closed_timer_reg <= flow_closed_timer_next;
            flow_open_timer_reg   <= flow_open_timer_next;
            overload_timer_reg    <= overload_timer_next;
            latched_reg           <= latched_next;
            sensor_lock_reg       <= sensor_lock_next;
            flow_confirmed_reg    <= flow_confirmed_next;
        end
    end

`ifndef NO_ASSERTIONS
    // Sensor lock is released only by reset
    a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        sensor_lock_reg |=> sensor_lock_reg)
        else $error("sensor lock released without reset");

    // Pump off always drops flow confirmation
    a_pump_off_unconfirms: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !item.pump_on) |=> !flow_confirmed_reg)
        else $error("flow confirmed while pump off");

    // Disabled run-time limit leaves no timeout fault
    a_timeout_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !cfg.time_limit_enable) |=> !latched_reg[csfm_pkg::F_TIME])
        else $error("timeout fault held with limit disabled");

    // State moves only with an evaluated item
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(latched_reg) && $stable(pump_start_timer_reg)))
        else $error("fault state changed without an item");
`endif

endmodule
